>>> rtl/core/cpat_pkg.sv
// Shared types, codes and operand schedules for the cospherical pair admission test.
// No dependencies; the top level, cpat_mac and cpat_checker refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cpat_pkg;

  // Default build values
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 4;

  // Accumulator width; every determinant fits exactly in this
  localparam int ACC_W  = 64;
  localparam int SIZE_W = 7;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_TEST   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_CMP,
    S_RM_LAST,
    S_RM_MOVE,
    S_RDI,
    S_LDI,
    S_BV,
    S_RDJ,
    S_LDJ,
    S_W,
    S_RDK,
    S_LDK,
    S_DOT
  } state_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clear;
    logic neg;
  } mac_ctrl_t;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
  } bv_pair_t;

  typedef struct packed {
    logic [2:0] bv;
    logic [1:0] y;
    logic       neg;
    logic       first;
    logic       last;
    logic [1:0] comp;
  } w_term_t;

  // Bivector element order: 01, 02, 03, 12, 13, 23
  function automatic bv_pair_t bv_pair(input logic [2:0] e);
    bv_pair_t r;
    case (e)
      3'd0:    r = '{a: 2'd0, b: 2'd1};
      3'd1:    r = '{a: 2'd0, b: 2'd2};
      3'd2:    r = '{a: 2'd0, b: 2'd3};
      3'd3:    r = '{a: 2'd1, b: 2'd2};
      3'd4:    r = '{a: 2'd1, b: 2'd3};
      default: r = '{a: 2'd2, b: 2'd3};
    endcase
    return r;
  endfunction

  // Trivector terms: three products per component, components 0..3
  function automatic w_term_t w_term(input logic [3:0] s);
    w_term_t r;
    case (s)
      4'd0:    r = '{bv: 3'd3, y: 2'd3, neg: 1'b0, first: 1'b1, last: 1'b0, comp: 2'd0};
      4'd1:    r = '{bv: 3'd4, y: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b0, comp: 2'd0};
      4'd2:    r = '{bv: 3'd5, y: 2'd1, neg: 1'b0, first: 1'b0, last: 1'b1, comp: 2'd0};
      4'd3:    r = '{bv: 3'd1, y: 2'd3, neg: 1'b1, first: 1'b1, last: 1'b0, comp: 2'd1};
      4'd4:    r = '{bv: 3'd2, y: 2'd2, neg: 1'b0, first: 1'b0, last: 1'b0, comp: 2'd1};
      4'd5:    r = '{bv: 3'd5, y: 2'd0, neg: 1'b1, first: 1'b0, last: 1'b1, comp: 2'd1};
      4'd6:    r = '{bv: 3'd0, y: 2'd3, neg: 1'b0, first: 1'b1, last: 1'b0, comp: 2'd2};
      4'd7:    r = '{bv: 3'd2, y: 2'd1, neg: 1'b1, first: 1'b0, last: 1'b0, comp: 2'd2};
      4'd8:    r = '{bv: 3'd4, y: 2'd0, neg: 1'b0, first: 1'b0, last: 1'b1, comp: 2'd2};
      4'd9:    r = '{bv: 3'd0, y: 2'd2, neg: 1'b1, first: 1'b1, last: 1'b0, comp: 2'd3};
      4'd10:   r = '{bv: 3'd1, y: 2'd1, neg: 1'b0, first: 1'b0, last: 1'b0, comp: 2'd3};
      default: r = '{bv: 3'd3, y: 2'd0, neg: 1'b1, first: 1'b0, last: 1'b1, comp: 2'd3};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cosphere_pair_admission_test.sv
// Top level: point store, command sequencer and the triple-subset determinant walk.
// Depends on cpat_pkg, cpat_ram and cpat_mac.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to MAX_POINTS grid points in a RAM and answers one result per command.
// Add and clear finish at acceptance (result in the next cycle). Remove scans the
// store one entry at a time (S_RM_RD, S_RM_CMP); on a match that is not the last
// entry it reads the last entry (S_RM_LAST) and writes it into the gap (S_RM_MOVE).
// A pair test with n >= 3 points walks every ordered triple i<j<k through one
// shared multiply-accumulate unit doing one product a cycle in its BV, W and DOT
// states: per i a read and a 12-product bivector, per j a read and a 12-product
// trivector and per k a read and a 4-product dot; it stops early at the first
// zero determinant. A new command is taken only when the sequencer is idle and
// the result slot is free or being emptied.
module cosphere_pair_admission_test #(
  parameter int MAX_POINTS = cpat_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cpat_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_command,
  input  wire logic [COORD_BITS-1:0]         in_ax,
  input  wire logic [COORD_BITS-1:0]         in_ay,
  input  wire logic [COORD_BITS-1:0]         in_az,
  input  wire logic [COORD_BITS-1:0]         in_bx,
  input  wire logic [COORD_BITS-1:0]         in_by_coord,
  input  wire logic [COORD_BITS-1:0]         in_bz,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [cpat_pkg::SIZE_W-1:0]        out_set_size
);

  localparam int CB = COORD_BITS;
  localparam int EW = 3 * CB;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = $clog2(3 * ((2 ** CB - 1) ** 2) + 1);
  localparam int UW = LW + 1;
  localparam int BW = 2 * UW + 1;
  localparam int WW = BW + UW + 2;

  // lifted coordinate c of a packed point: x, y, z or x*x+y*y+z*z
  function automatic logic signed [UW-1:0] lift_c(input logic [EW-1:0] e,
                                                 input logic [1:0] c);
    logic [LW-1:0] xx;
    logic [LW-1:0] yy;
    logic [LW-1:0] zz;
    logic [LW-1:0] r;
    xx = LW'(e[EW-1:2*CB]);
    yy = LW'(e[2*CB-1:CB]);
    zz = LW'(e[CB-1:0]);
    case (c)
      2'd0:    r = xx;
      2'd1:    r = yy;
      2'd2:    r = zz;
      default: r = xx * xx + yy * yy + zz * zz;
    endcase
    return $signed({1'b0, r});
  endfunction

  cpat_pkg::state_t state_r, state_nxt;

  logic [EW-1:0]          pa_r;
  logic signed [UW-1:0]   p_r  [4];
  logic signed [UW-1:0]   v_r  [4];
  logic signed [UW-1:0]   ui_r [4];
  logic signed [UW-1:0]   uj_r [4];
  logic signed [UW-1:0]   uk_r [4];
  logic signed [UW-1:0]   u_rd [4];
  logic signed [BW-1:0]   bv_r [6];
  logic signed [WW-1:0]   w_r  [4];
  logic [3:0]             step_r;
  logic [CW-1:0]          i_r, j_r, k_r;
  logic [CW-1:0]          cnt_r, cnt_nxt;

  logic                   out_valid_r;
  cpat_pkg::status_t      out_status_r;
  logic [cpat_pkg::SIZE_W-1:0] out_size_r;

  logic                   accept;
  cpat_pkg::cmd_t         cmd;
  logic [EW-1:0]          in_pa, in_pb;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [EW-1:0]          ram_wdata, ram_rdata;

  cpat_pkg::mac_ctrl_t    mac_ctrl;
  logic signed [WW-1:0]   mac_a;
  logic signed [UW-1:0]   mac_b;
  logic signed [cpat_pkg::ACC_W-1:0] mac_sum;

  cpat_pkg::bv_pair_t     bvp;
  cpat_pkg::w_term_t      wt;

  logic                   done;
  cpat_pkg::status_t      done_status;
  logic                   rm_match;
  logic                   dot_zero;
  logic                   at_last;
  logic                   k_more, j_more, i_more;

  // input handshake
  assign in_stall = !((state_r == cpat_pkg::S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign cmd      = cpat_pkg::cmd_t'(in_command);
  assign in_pa    = {in_ax, in_ay, in_az};
  assign in_pb    = {in_bx, in_by_coord, in_bz};

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_set_size = out_size_r;

  // lifted, shifted point from the RAM read port
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      u_rd[c] = lift_c(ram_rdata, 2'(c)) - p_r[c];
    end
  end

  assign bvp      = cpat_pkg::bv_pair(step_r[3:1]);
  assign wt       = cpat_pkg::w_term(step_r);
  assign rm_match = (ram_rdata == pa_r);
  assign dot_zero = (mac_sum == '0);
  assign at_last  = (i_r == cnt_r - CW'(1));
  assign k_more   = ((k_r + CW'(1)) < cnt_r);
  assign j_more   = ((j_r + CW'(2)) < cnt_r);
  assign i_more   = ((i_r + CW'(3)) < cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpat_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd == cpat_pkg::CMD_REMOVE && cnt_r != '0) begin
            state_nxt = cpat_pkg::S_RM_RD;
          end else if (cmd == cpat_pkg::CMD_TEST && cnt_r >= CW'(3)) begin
            state_nxt = cpat_pkg::S_RDI;
          end
        end
      end
      cpat_pkg::S_RM_RD:   state_nxt = cpat_pkg::S_RM_CMP;
      cpat_pkg::S_RM_CMP: begin
        priority if (rm_match && at_last) state_nxt = cpat_pkg::S_IDLE;
        else if (rm_match)                state_nxt = cpat_pkg::S_RM_LAST;
        else if (at_last)                 state_nxt = cpat_pkg::S_IDLE;
        else                              state_nxt = cpat_pkg::S_RM_RD;
      end
      cpat_pkg::S_RM_LAST: state_nxt = cpat_pkg::S_RM_MOVE;
      cpat_pkg::S_RM_MOVE: state_nxt = cpat_pkg::S_IDLE;
      cpat_pkg::S_RDI:     state_nxt = cpat_pkg::S_LDI;
      cpat_pkg::S_LDI:     state_nxt = cpat_pkg::S_BV;
      cpat_pkg::S_BV:      if (step_r == 4'd11) state_nxt = cpat_pkg::S_RDJ;
      cpat_pkg::S_RDJ:     state_nxt = cpat_pkg::S_LDJ;
      cpat_pkg::S_LDJ:     state_nxt = cpat_pkg::S_W;
      cpat_pkg::S_W:       if (step_r == 4'd11) state_nxt = cpat_pkg::S_RDK;
      cpat_pkg::S_RDK:     state_nxt = cpat_pkg::S_LDK;
      cpat_pkg::S_LDK:     state_nxt = cpat_pkg::S_DOT;
      cpat_pkg::S_DOT: begin
        if (step_r == 4'd3) begin
          priority if (dot_zero) state_nxt = cpat_pkg::S_IDLE;
          else if (k_more)       state_nxt = cpat_pkg::S_RDK;
          else if (j_more)       state_nxt = cpat_pkg::S_RDJ;
          else if (i_more)       state_nxt = cpat_pkg::S_RDI;
          else                   state_nxt = cpat_pkg::S_IDLE;
        end
      end
      default:             state_nxt = cpat_pkg::S_IDLE;
    endcase
  end

  // datapath control, RAM ports, MAC operands and completion
  always_comb begin
    done        = 1'b0;
    done_status = cpat_pkg::ST_OK;
    cnt_nxt     = cnt_r;
    ram_we      = 1'b0;
    ram_waddr   = i_r[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = i_r[AW-1:0];
    mac_ctrl    = '0;
    mac_a       = '0;
    mac_b       = '0;
    unique case (state_r)
      cpat_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            cpat_pkg::CMD_ADD: begin
              done = 1'b1;
              if (cnt_r == CW'(MAX_POINTS)) begin
                done_status = cpat_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = in_pa;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            cpat_pkg::CMD_CLEAR: begin
              done    = 1'b1;
              cnt_nxt = '0;
            end
            cpat_pkg::CMD_REMOVE: begin
              if (cnt_r == '0) begin
                done        = 1'b1;
                done_status = cpat_pkg::ST_ABSENT;
              end
            end
            cpat_pkg::CMD_TEST: begin
              if (cnt_r < CW'(3)) begin
                done = 1'b1;
              end
            end
          endcase
        end
      end
      cpat_pkg::S_RM_CMP: begin
        if (rm_match && at_last) begin
          done    = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end else if (!rm_match && at_last) begin
          done        = 1'b1;
          done_status = cpat_pkg::ST_ABSENT;
        end
      end
      cpat_pkg::S_RM_LAST: begin
        ram_raddr = AW'(cnt_r - CW'(1));
      end
      cpat_pkg::S_RM_MOVE: begin
        // last entry fills the freed slot
        done    = 1'b1;
        ram_we  = 1'b1;
        cnt_nxt = cnt_r - CW'(1);
      end
      cpat_pkg::S_RDJ: ram_raddr = j_r[AW-1:0];
      cpat_pkg::S_RDK: ram_raddr = k_r[AW-1:0];
      cpat_pkg::S_BV: begin
        // bv[a][b] = ui[a]*v[b] - ui[b]*v[a]
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = !step_r[0];
        mac_ctrl.neg   = step_r[0];
        mac_a = step_r[0] ? WW'(ui_r[bvp.b]) : WW'(ui_r[bvp.a]);
        mac_b = step_r[0] ? v_r[bvp.a] : v_r[bvp.b];
      end
      cpat_pkg::S_W: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = wt.first;
        mac_ctrl.neg   = wt.neg;
        mac_a = WW'(bv_r[wt.bv]);
        mac_b = uj_r[wt.y];
      end
      cpat_pkg::S_DOT: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = (step_r == 4'd0);
        mac_a = w_r[step_r[1:0]];
        mac_b = uk_r[step_r[1:0]];
        if (step_r == 4'd3) begin
          if (dot_zero) begin
            done        = 1'b1;
            done_status = cpat_pkg::ST_CONFLICT;
          end else if (!k_more && !j_more && !i_more) begin
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpat_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and loop registers
  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= done_status;
      out_size_r   <= cpat_pkg::SIZE_W'(cnt_nxt);
    end
    unique case (state_r)
      cpat_pkg::S_IDLE: begin
        if (accept) begin
          pa_r <= in_pa;
          i_r  <= '0;
          for (int c = 0; c < 4; c++) begin
            p_r[c] <= lift_c(in_pa, 2'(c));
            v_r[c] <= lift_c(in_pb, 2'(c)) - lift_c(in_pa, 2'(c));
          end
        end
      end
      cpat_pkg::S_RM_CMP: begin
        if (!rm_match) begin
          i_r <= i_r + CW'(1);
        end
      end
      cpat_pkg::S_LDI: begin
        ui_r   <= u_rd;
        j_r    <= i_r + CW'(1);
        step_r <= '0;
      end
      cpat_pkg::S_BV: begin
        if (step_r[0]) begin
          bv_r[step_r[3:1]] <= $signed(mac_sum[BW-1:0]);
        end
        step_r <= step_r + 4'd1;
      end
      cpat_pkg::S_LDJ: begin
        uj_r   <= u_rd;
        k_r    <= j_r + CW'(1);
        step_r <= '0;
      end
      cpat_pkg::S_W: begin
        if (wt.last) begin
          w_r[wt.comp] <= $signed(mac_sum[WW-1:0]);
        end
        step_r <= step_r + 4'd1;
      end
      cpat_pkg::S_LDK: begin
        uk_r   <= u_rd;
        step_r <= '0;
      end
      cpat_pkg::S_DOT: begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd3) begin
          priority if (k_more) begin
            k_r <= k_r + CW'(1);
          end else if (j_more) begin
            j_r <= j_r + CW'(1);
          end else if (i_more) begin
            i_r <= i_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  cpat_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpat_mac #(
    .A_W (WW),
    .B_W (UW)
  ) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .sum  (mac_sum)
  );

endmodule

`default_nettype wire

>>> rtl/core/cpat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpat_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/cpat_mac.sv
// Shared signed multiply-accumulate unit; the sum output is taken before the accumulator register.
// Depends on cpat_pkg (ACC_W, mac_ctrl_t).
`timescale 1ns / 1ps
`default_nettype none

module cpat_mac #(
  parameter int A_W = 48,
  parameter int B_W = 15
) (
  input  wire logic                            clk,
  input  wire cpat_pkg::mac_ctrl_t             ctrl,
  input  wire logic signed [A_W-1:0]           op_a,
  input  wire logic signed [B_W-1:0]           op_b,
  output logic signed [cpat_pkg::ACC_W-1:0]    sum
);

  logic signed [A_W+B_W-1:0]           prod;
  logic signed [cpat_pkg::ACC_W-1:0]   prod_ext;
  logic signed [cpat_pkg::ACC_W-1:0]   base;
  logic signed [cpat_pkg::ACC_W-1:0]   acc_r;

  // one product per cycle while ctrl.en is set, added to or taken from the running sum (or zero on clear)
  assign prod     = op_a * op_b;
  assign prod_ext = cpat_pkg::ACC_W'(prod);
  assign base     = ctrl.clear ? '0 : acc_r;
  assign sum      = ctrl.neg ? (base - prod_ext) : (base + prod_ext);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= sum;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cpat_checker.sv
// Port-level checks for the cospherical pair admission test, bound to the top level.
// Depends on cpat_pkg (status codes, SIZE_W).
`timescale 1ns / 1ps
`default_nettype none

module cpat_checker #(
  parameter int MAX_POINTS = cpat_pkg::MAX_POINTS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [1:0]                  out_status,
  input wire logic [cpat_pkg::SIZE_W-1:0] out_set_size
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_set_size))
    else $error("result changed while stalled");

  // no new transaction while a result is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("transaction accepted over a blocked result");

  // a full status reports a full set
  a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cpat_pkg::ST_FULL |->
      out_set_size == cpat_pkg::SIZE_W'(MAX_POINTS))
    else $error("full status with wrong set size");

  // set size never exceeds capacity (checked only for MAX_POINTS up to 127)
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (MAX_POINTS > 127) || (int'(out_set_size) <= MAX_POINTS))
    else $error("set size beyond capacity");

endmodule

bind cosphere_pair_admission_test cpat_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_cpat_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_set_size (out_set_size)
);

`default_nettype wire
